// ===== rtl/core/otpm_pkg.sv =====
// Shared types, constants and helper functions for the orientation to pointer mapper.
package otpm_pkg;

  localparam int QW = 16;      // quaternion component width
  localparam int PW = 32;      // component product width
  localparam int EW = 20;      // rotation matrix entry width, Q14
  localparam int MW = 40;      // entry product width, Q28
  localparam int DW = 44;      // delta and CORDIC vector width
  localparam int QB = 15;      // quotient bits below the clamp limit
  localparam int TABLE_LEN = 24;
  localparam longint HALFPI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam int ONE_Q14 = 16384;
  localparam int RANGE_MAX = 4096;

  typedef enum logic [2:0] {
    REG_REF_W     = 3'd0,
    REG_REF_X     = 3'd1,
    REG_REF_Y     = 3'd2,
    REG_REF_Z     = 3'd3,
    REG_CAL       = 3'd4,
    REG_YAW_RANGE = 3'd5,
    REG_PIT_RANGE = 3'd6,
    REG_INVERT    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [PW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  } prod_t;

  typedef struct packed {
    logic signed [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  function automatic longint atan_q30(int i);
    longint t;
    case (i)
      0:  t = 843314857;
      1:  t = 497837829;
      2:  t = 263043837;
      3:  t = 133525159;
      4:  t = 67021687;
      5:  t = 33543516;
      6:  t = 16775851;
      7:  t = 8388437;
      8:  t = 4194283;
      9:  t = 2097149;
      10: t = 1048576;
      11: t = 524288;
      12: t = 262144;
      13: t = 131072;
      14: t = 65536;
      15: t = 32768;
      16: t = 16384;
      17: t = 8192;
      18: t = 4096;
      19: t = 2048;
      20: t = 1024;
      21: t = 512;
      22: t = 256;
      23: t = 128;
      default: t = 0;
    endcase
    return t;
  endfunction

  // round half up, dropping sh fraction bits
  function automatic longint rnd_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic prod_t quat_prod(logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                                      logic signed [QW-1:0] y, logic signed [QW-1:0] z);
    prod_t p;
    p.xx = x * x;
    p.yy = y * y;
    p.zz = z * z;
    p.xy = x * y;
    p.xz = x * z;
    p.yz = y * z;
    p.wx = w * x;
    p.wy = w * y;
    p.wz = w * z;
    return p;
  endfunction

  // Q28 diagonal entry 1 - 2(a+b), rounded to Q14
  function automatic logic signed [EW-1:0] diag_ent(logic signed [PW-1:0] a,
                                                    logic signed [PW-1:0] b);
    logic signed [35:0] v;
    v = (36'sd1 <<< 28) - 36'(a) * 2 - 36'(b) * 2 + (36'sd1 <<< 13);
    return EW'(v >>> 14);
  endfunction

  // Q28 off-diagonal entry 2(a +- b), rounded to Q14
  function automatic logic signed [EW-1:0] cross_ent(logic signed [PW-1:0] a,
                                                     logic signed [PW-1:0] b, logic sub);
    logic signed [35:0] v;
    v = sub ? (36'(a) - 36'(b)) : (36'(a) + 36'(b));
    v = v * 2 + (36'sd1 <<< 13);
    return EW'(v >>> 14);
  endfunction

  function automatic mat_t quat_mat(prod_t p);
    mat_t m;
    m.m00 = diag_ent(p.yy, p.zz);
    m.m01 = cross_ent(p.xy, p.wz, 1'b1);
    m.m02 = cross_ent(p.xz, p.wy, 1'b0);
    m.m10 = cross_ent(p.xy, p.wz, 1'b0);
    m.m11 = diag_ent(p.xx, p.zz);
    m.m12 = cross_ent(p.yz, p.wx, 1'b1);
    m.m20 = cross_ent(p.xz, p.wy, 1'b1);
    m.m21 = cross_ent(p.yz, p.wx, 1'b0);
    m.m22 = diag_ent(p.xx, p.yy);
    return m;
  endfunction

endpackage

// ===== rtl/core/orientation_to_pointer_mapper_top.sv =====
// Top level: quaternion to pointer mapper, fully pipelined.
// Throughput: one transaction per cycle while in_stall is low; every stage is one multiply or one add/compare.
// Back pressure: one-entry output skid; in_stall is high while it is full, freezing the pipe.
// Reset (rst, synchronous, active high): clears all valid bits and loads the identity
//   reference, uncalibrated, full ranges, no inversion. Samples while uncalibrated drop.
module orientation_to_pointer_mapper_top
  import otpm_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 14,
  parameter int ATAN_ITERATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   pointer_x,
  output logic signed [15:0]   pointer_y
);

  localparam int A    = ANGLE_FRAC_BITS;
  localparam int ITER = ATAN_ITERATIONS;
  localparam int AW   = A + 4;        // angle width, |angle| < 8 rad
  localparam int NW   = A + 30;       // dividend width
  localparam int DENW = A + 14;       // divisor width
  localparam int SH   = 30 - A;
  localparam logic signed [AW-1:0] PI_A = AW'(rnd_shift(PI_Q30, SH));
  localparam logic [A+1:0] HALFPI_A = (A + 2)'(rnd_shift(HALFPI_Q30, SH));

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } cord_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QB-1:0] q;
    logic          neg;
    logic          zero;
    logic          sat;
  } div_t;

  // ---------------- configuration registers ----------------
  logic signed [QW-1:0] ref_w, ref_x, ref_y, ref_z;
  logic                 calibrated;
  logic [12:0]          yaw_range, pitch_range;
  logic [1:0]           invert_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_w        <= QW'(ONE_Q14);
      ref_x        <= '0;
      ref_y        <= '0;
      ref_z        <= '0;
      calibrated   <= 1'b0;
      yaw_range    <= 13'(RANGE_MAX);
      pitch_range  <= 13'(RANGE_MAX);
      invert_flags <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_REF_W:     ref_w        <= cfg_data;
        REG_REF_X:     ref_x        <= cfg_data;
        REG_REF_Y:     ref_y        <= cfg_data;
        REG_REF_Z:     ref_z        <= cfg_data;
        REG_CAL:       calibrated   <= cfg_data[0];
        REG_YAW_RANGE: yaw_range    <= cfg_data[12:0];
        REG_PIT_RANGE: pitch_range  <= cfg_data[12:0];
        REG_INVERT:    invert_flags <= cfg_data[1:0];
        default:       ;
      endcase
    end
  end

  // Derived constants, refreshed every cycle. The user must move config only while the block
  // is idle (not enforced here), so these settle long before a sample reaches the stages using them.
  prod_t        ref_prod;
  mat_t         rm;
  logic [12:0]  range_c [2];
  logic [DENW-1:0] den [2];
  logic         rzero [2];

  assign range_c[0] = (yaw_range > 13'(RANGE_MAX)) ? 13'(RANGE_MAX) : yaw_range;
  assign range_c[1] = (pitch_range > 13'(RANGE_MAX)) ? 13'(RANGE_MAX) : pitch_range;

  always_ff @(posedge clk) begin
    ref_prod <= quat_prod(ref_w, ref_x, ref_y, ref_z);
    rm       <= quat_mat(ref_prod);
    for (int c = 0; c < 2; c++) begin
      den[c]   <= DENW'(HALFPI_A * range_c[c]);
      rzero[c] <= (range_c[c] == '0);
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // stage 1: component products
  logic  v1;
  prod_t cp;
  // stage 2: matrix entries
  logic  v2;
  mat_t  cm;
  // stage 3: delta term products
  logic  v3;
  logic signed [MW-1:0] p00 [3], p10 [3], p21 [3], p22 [3];
  // stage 4: delta sums
  logic  v4;
  logic signed [DW-1:0] d00, d10, d21, d22;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && calibrated;   // uncalibrated samples are taken and dropped
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp <= quat_prod(quat_w, quat_x, quat_y, quat_z);
      cm <= quat_mat(cp);
      // delta = ref^T * cur, only the four entries the angles need
      p00[0] <= rm.m00 * cm.m00; p00[1] <= rm.m10 * cm.m10; p00[2] <= rm.m20 * cm.m20;
      p10[0] <= rm.m01 * cm.m00; p10[1] <= rm.m11 * cm.m10; p10[2] <= rm.m21 * cm.m20;
      p21[0] <= rm.m02 * cm.m01; p21[1] <= rm.m12 * cm.m11; p21[2] <= rm.m22 * cm.m21;
      p22[0] <= rm.m02 * cm.m02; p22[1] <= rm.m12 * cm.m12; p22[2] <= rm.m22 * cm.m22;
      d00 <= DW'(p00[0]) + DW'(p00[1]) + DW'(p00[2]);
      d10 <= DW'(p10[0]) + DW'(p10[1]) + DW'(p10[2]);
      d21 <= DW'(p21[0]) + DW'(p21[1]) + DW'(p21[2]);
      d22 <= DW'(p22[0]) + DW'(p22[1]) + DW'(p22[2]);
    end
  end

  // ---------------- CORDIC vectoring, channel 0 yaw, channel 1 pitch ----------------
  logic  vc [0:ITER];
  cord_t cr [0:ITER][2];
  logic signed [DW-1:0] ax [2], ay [2];

  assign ax[0] = d00;
  assign ay[0] = d10;
  assign ax[1] = d22;
  assign ay[1] = d21;

  // entry stage folds the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (rst) begin
      vc[0] <= 1'b0;
    end else if (en) begin
      vc[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        cr[0][c].zero <= (ax[c] == '0) && (ay[c] == '0);
        if (ax[c] < 0) begin
          cr[0][c].x <= -ax[c];
          cr[0][c].y <= -ay[c];
          cr[0][c].z <= (ay[c] >= 0) ? PI_A : -PI_A;
        end else begin
          cr[0][c].x <= ax[c];
          cr[0][c].y <= ay[c];
          cr[0][c].z <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_cordic
    localparam logic signed [AW-1:0] T = AW'(rnd_shift(atan_q30(i), SH));

    always_ff @(posedge clk) begin
      if (rst) begin
        vc[i+1] <= 1'b0;
      end else if (en) begin
        vc[i+1] <= vc[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 2; c++) begin
          cr[i+1][c].zero <= cr[i][c].zero;
          if (cr[i][c].y >= 0) begin
            cr[i+1][c].x <= cr[i][c].x + (cr[i][c].y >>> i);
            cr[i+1][c].y <= cr[i][c].y - (cr[i][c].x >>> i);
            cr[i+1][c].z <= cr[i][c].z + T;
          end else begin
            cr[i+1][c].x <= cr[i][c].x - (cr[i][c].y >>> i);
            cr[i+1][c].y <= cr[i][c].y + (cr[i][c].x >>> i);
            cr[i+1][c].z <= cr[i][c].z - T;
          end
        end
      end
    end
  end

  // ---------------- scaling: round(|angle| * 2^26 / den), one quotient bit a stage ----------------
  logic vd [0:QB];
  div_t dv [0:QB][2];
  logic signed [AW-1:0] ang [2];
  logic [AW-1:0]        mag [2];
  logic [NW-1:0]        num [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      ang[c] = cr[ITER][c].zero ? '0 : cr[ITER][c].z;
      mag[c] = (ang[c] < 0) ? AW'(-ang[c]) : AW'(ang[c]);
      num[c] = (NW'(mag[c]) << 26) + NW'(den[c] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (en) begin
      vd[0] <= vc[ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        dv[0][c].rem  <= num[c];
        dv[0][c].q    <= '0;
        dv[0][c].zero <= (ang[c] == '0);
        // the result is negated; inversion flips it back
        dv[0][c].neg  <= (ang[c] > 0) ^ invert_flags[c];
        // zero range, or quotient of 2^QB or more, ends at full scale
        dv[0][c].sat  <= rzero[c] || (num[c] >= (NW'(den[c]) << QB));
      end
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int B = QB - j;
    div_t dv_next [2];

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j] <= 1'b0;
      end else if (en) begin
        vd[j] <= vd[j-1];
      end
    end

    always_comb begin
      for (int c = 0; c < 2; c++) begin
        dv_next[c] = dv[j-1][c];
        if (dv[j-1][c].rem >= (NW'(den[c]) << B)) begin
          dv_next[c].rem  = dv[j-1][c].rem - (NW'(den[c]) << B);
          dv_next[c].q[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 2; c++) begin
          dv[j][c] <= dv_next[c];
        end
      end
    end
  end

  // clamp and sign
  logic signed [15:0] fin [2];
  logic [QB-1:0]      qc [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (dv[QB][c].sat || (dv[QB][c].q > QB'(ONE_Q14))) begin
        qc[c] = QB'(ONE_Q14);
      end else begin
        qc[c] = dv[QB][c].q;
      end
      if (dv[QB][c].zero) begin
        fin[c] = '0;
      end else if (dv[QB][c].neg) begin
        fin[c] = -$signed(16'(qc[c]));
      end else begin
        fin[c] = $signed(16'(qc[c]));
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic signed [15:0] skid_x, skid_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= vd[QB];
      end
    end else if (vd[QB] && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      pointer_x <= skid_valid ? skid_x : fin[0];
      pointer_y <= skid_valid ? skid_y : fin[1];
    end else if (en) begin
      skid_x <= fin[0];
      skid_y <= fin[1];
    end
  end

endmodule

// ===== rtl/core/otpm_checker.sv =====
// Port-level checker for the orientation to pointer mapper, bound to the top level.
module otpm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] pointer_x,
  input logic signed [15:0] pointer_y
);

  // a held transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pointer_x) && $stable(pointer_y))
    else $error("output changed while stalled");

  // results stay within +-1.0 in Q1.14
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pointer_x >= -16'sd16384 && pointer_x <= 16'sd16384 &&
                  pointer_y >= -16'sd16384 && pointer_y <= 16'sd16384)
    else $error("pointer out of range");

  // input back pressure only follows a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without output stall");

  // a full skid implies a result waiting at the output
  a_stall_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind orientation_to_pointer_mapper_top otpm_checker u_otpm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pointer_x (pointer_x),
  .pointer_y (pointer_y)
);

// ===== bench/orientation_to_pointer_mapper_top_tb.sv =====
// Self-checking bench for the orientation to pointer mapper: random traffic, scoreboard.
module orientation_to_pointer_mapper_top_tb;
  import otpm_pkg::*;

  localparam int FRAC = 14;       // angle fraction bits, matches the DUT default
  localparam int ITERS = 16;      // CORDIC steps, matches the DUT default
  localparam int DRAIN = 60;      // pipeline depth plus margin
  localparam int WDOG_LIMIT = 5000;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] px, py;
  } ptr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] pointer_x, pointer_y;

  always #5 clk = ~clk;

  orientation_to_pointer_mapper_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .pointer_x(pointer_x), .pointer_y(pointer_y)
  );

  // Mirror of the configuration registers, updated as writes are issued.
  quat_t ref_q;
  logic cal_en;
  logic [12:0] yaw_rng, pitch_rng;
  logic [1:0] inv_flags;

  quat_t pending_samples[$];
  ptr_t expected_ptrs[$];
  int errors = 0;
  int samples_sent = 0;
  int ptrs_seen = 0;
  int idle_cycles = 0;

  // -------------------------------------------------------------------------
  // Predictor arithmetic (independent of the RTL package functions)
  // -------------------------------------------------------------------------
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;   // arithmetic shift on signed longint floors
  endfunction

  function automatic longint round_q(longint v, int n);
    return floor_shr(v + (longint'(1) << (n - 1)), n);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149,
                        1048576, 524288, 262144, 131072, 65536, 32768,
                        16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return tbl[i];
  endfunction

  // Rotation matrix of a Q1.14 quaternion, Q14 entries, row-major.
  function automatic void rot_matrix(quat_t q, output longint m[9]);
    longint w, x, y, z, one;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one = longint'(1) << 28;
    m[0] = round_q(one - 2 * (y * y + z * z), 14);
    m[1] = round_q(2 * (x * y - w * z), 14);
    m[2] = round_q(2 * (x * z + w * y), 14);
    m[3] = round_q(2 * (x * y + w * z), 14);
    m[4] = round_q(one - 2 * (x * x + z * z), 14);
    m[5] = round_q(2 * (y * z - w * x), 14);
    m[6] = round_q(2 * (x * z - w * y), 14);
    m[7] = round_q(2 * (y * z + w * x), 14);
    m[8] = round_q(one - 2 * (x * x + y * y), 14);
  endfunction

  // Vectoring CORDIC arctangent; left-half-plane vectors fold over by pi.
  function automatic longint cordic_angle(longint ya, longint xa);
    longint ang, xs, ys;
    ang = 0;
    if (xa == 0 && ya == 0) return 0;
    if (xa < 0) begin
      ang = (ya >= 0) ? round_q(PI_Q30, 30 - FRAC) : -round_q(PI_Q30, 30 - FRAC);
      xa = -xa;
      ya = -ya;
    end
    for (int i = 0; i < ITERS; i++) begin
      xs = floor_shr(xa, i);
      ys = floor_shr(ya, i);
      if (ya >= 0) begin
        xa += ys; ya -= xs; ang += round_q(atan_step(i), 30 - FRAC);
      end else begin
        xa -= ys; ya += xs; ang -= round_q(atan_step(i), 30 - FRAC);
      end
    end
    return ang;
  endfunction

  // Angle to pointer fraction; zero range saturates by sign.
  function automatic logic signed [15:0] angle_to_frac(longint ang, logic [12:0] rng,
                                                       logic inv);
    longint r, mag, den, q, v;
    bit neg;
    if (ang == 0) return '0;
    r = (rng > RANGE_MAX) ? RANGE_MAX : rng;
    neg = (ang > 0) ^ inv;
    if (r == 0) begin
      v = ONE_Q14;
    end else begin
      mag = (ang < 0 ? -ang : ang) << 26;
      den = round_q(HALFPI_Q30, 30 - FRAC) * r;
      q = (mag + den / 2) / den;
      v = (q > ONE_Q14) ? ONE_Q14 : q;
    end
    return 16'(neg ? -v : v);
  endfunction

  function automatic ptr_t predict_pointer(quat_t cur);
    longint rm[9], cm[9];
    longint d00, d10, d21, d22;
    ptr_t p;
    rot_matrix(ref_q, rm);
    rot_matrix(cur, cm);
    // delta = ref^T * cur
    d00 = rm[0] * cm[0] + rm[3] * cm[3] + rm[6] * cm[6];
    d10 = rm[1] * cm[0] + rm[4] * cm[3] + rm[7] * cm[6];
    d21 = rm[2] * cm[1] + rm[5] * cm[4] + rm[8] * cm[7];
    d22 = rm[2] * cm[2] + rm[5] * cm[5] + rm[8] * cm[8];
    p.px = angle_to_frac(cordic_angle(d10, d00), yaw_rng, inv_flags[0]);
    p.py = angle_to_frac(cordic_angle(d21, d22), pitch_rng, inv_flags[1]);
    return p;
  endfunction

  // -------------------------------------------------------------------------
  // Input driver: pops the sample queue, random gap before each transaction.
  // The prediction is queued at acceptance while calibrated, with the config live at that time.
  // -------------------------------------------------------------------------
  int in_gap = 0;
  bit feed_en = 1'b0;
  bit gaps_on = 1'b1;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        samples_sent <= samples_sent + 1;
        if (cal_en) expected_ptrs.push_back(predict_pointer({quat_w, quat_x, quat_y, quat_z}));
      end
      if (!in_valid || !in_stall) begin
        if (in_valid && !in_stall) begin
          in_gap = gaps_on ? $urandom_range(0, 17) : 0;
          if ($urandom_range(0, 3) == 0) in_gap = 0;
        end
        if (in_gap > 0 || !feed_en || pending_samples.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          quat_t s;
          s = pending_samples.pop_front();
          in_valid <= 1'b1;
          {quat_w, quat_x, quat_y, quat_z} <= s;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output monitor: random stall per result, scoreboard compare.
  // -------------------------------------------------------------------------
  int out_gap = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        ptrs_seen <= ptrs_seen + 1;
        if (expected_ptrs.size() == 0) begin
          $error("unexpected result transaction: pointer_x=%0d pointer_y=%0d",
                 pointer_x, pointer_y);
          errors++;
        end else begin
          ptr_t e;
          e = expected_ptrs.pop_front();
          if (pointer_x !== e.px) begin
            $error("pointer_x expected %0d actual %0d", e.px, pointer_x);
            errors++;
          end
          if (pointer_y !== e.py) begin
            $error("pointer_y expected %0d actual %0d", e.py, pointer_y);
            errors++;
          end
        end
        out_gap = gaps_on ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) out_gap = 0;
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no transaction in %0d cycles", WDOG_LIMIT);
      $display("orientation_to_pointer_mapper_top_tb: errors");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencing
  // -------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_REF_W:     ref_q.w = val;
      REG_REF_X:     ref_q.x = val;
      REG_REF_Y:     ref_q.y = val;
      REG_REF_Z:     ref_q.z = val;
      REG_CAL:       cal_en = val[0];
      REG_YAW_RANGE: yaw_rng = val[12:0];
      REG_PIT_RANGE: pitch_rng = val[12:0];
      REG_INVERT:    inv_flags = val[1:0];
      default: ;
    endcase
  endtask

  // Run the queued samples, then wait for the pipe to drain fully.
  task automatic run_phase();
    feed_en = 1'b1;
    while (pending_samples.size() != 0 || in_valid) @(posedge clk);
    feed_en = 1'b0;
    while (expected_ptrs.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);                        // out of range, all bits
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Mostly near-unit quaternions: random axis-ish components, w fills the rest.
  function automatic quat_t rand_quat();
    quat_t q;
    real a, b, c, s;
    if ($urandom_range(0, 4) == 0) begin
      q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    end else begin
      a = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0 * 0.7;
      b = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0 * 0.7;
      c = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0 * 0.7;
      s = 1.0 - a * a - b * b - c * c;
      s = (s > 0.0) ? $sqrt(s) : 0.0;
      if ($urandom_range(0, 1)) s = -s;
      q.w = 16'($rtoi(s * 16384.0));
      q.x = 16'($rtoi(a * 16384.0));
      q.y = 16'($rtoi(b * 16384.0));
      q.z = 16'($rtoi(c * 16384.0));
    end
    return q;
  endfunction

  function automatic logic [15:0] rand_range();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd4096;
      2: return 16'($urandom_range(4097, 8191));   // above a quarter turn
      default: return 16'($urandom_range(1, 4096));
    endcase
  endfunction

  initial begin
    quat_t rq;
    ref_q = {16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    cal_en = 1'b0;
    yaw_rng = 13'd4096;
    pitch_rng = 13'd4096;
    inv_flags = 2'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Uncalibrated: every sample is dropped.
    repeat (4) pending_samples.push_back(rand_quat());
    run_phase();

    // Directed: identity reference, calibrated, field extremes and special cases.
    write_reg(REG_CAL, 16'd1);
    pending_samples.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});     // zero angle
    pending_samples.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0});         // zero quaternion, identity matrix
    pending_samples.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_samples.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});     // yaw = pi
    pending_samples.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd0});     // pitch = pi
    pending_samples.push_back({16'sd11585, 16'sd0, 16'sd0, 16'sd11585}); // quarter yaw
    pending_samples.push_back({16'sd11585, 16'sd0, 16'sd0, -16'sd11585});
    pending_samples.push_back({16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
    pending_samples.push_back({16'sd11585, -16'sd11585, 16'sd0, 16'sd0});
    pending_samples.push_back({16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
    pending_samples.push_back({-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
    pending_samples.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});  // non-unit
    pending_samples.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    pending_samples.push_back({16'hffff, 16'h5555, 16'haaaa, 16'h0001});
    run_phase();

    // Zero range saturates; invert both; over-range acts as a full quarter turn.
    write_reg(REG_YAW_RANGE, 16'd0);
    write_reg(REG_PIT_RANGE, 16'd8191);
    write_reg(REG_INVERT, 16'd3);
    pending_samples.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_samples.push_back({16'sd15000, 16'sd2000, 16'sd0, 16'sd5000});
    pending_samples.push_back({16'sd15000, -16'sd2000, 16'sd0, -16'sd5000});
    pending_samples.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    run_phase();

    // Random phases, each with a fresh configuration and reference pose.
    for (int ph = 0; ph < 12; ph++) begin
      rq = (ph % 4 == 3) ? {rand_comp(), rand_comp(), rand_comp(), rand_comp()} : rand_quat();
      write_reg(REG_REF_W, rq.w);
      write_reg(REG_REF_X, rq.x);
      write_reg(REG_REF_Y, rq.y);
      write_reg(REG_REF_Z, rq.z);
      write_reg(REG_YAW_RANGE, rand_range());
      write_reg(REG_PIT_RANGE, rand_range());
      write_reg(REG_INVERT, 16'($urandom_range(0, 3)));
      write_reg(REG_CAL, (ph == 5) ? 16'd0 : 16'd1);   // one dropped phase
      gaps_on = (ph % 3 != 1);                          // some phases run back to back
      repeat (100) pending_samples.push_back(rand_quat());
      run_phase();
    end

    $display("covered %0d samples and %0d pointer results over 15 config phases",
             samples_sent, ptrs_seen);
    if (errors == 0 && expected_ptrs.size() == 0) begin
      $display("orientation_to_pointer_mapper_top_tb: clean");
    end else begin
      $display("orientation_to_pointer_mapper_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== orientation_to_pointer_mapper_top.f =====
rtl/core/otpm_pkg.sv
rtl/core/orientation_to_pointer_mapper_top.sv
rtl/core/otpm_checker.sv
bench/orientation_to_pointer_mapper_top_tb.sv
